// ----- design/lcg_pattern_generator_checker_assert.svh -----
// Assertion macros used by the top-level design file.
`ifndef LCG_PATTERN_GENERATOR_CHECKER_ASSERT_SVH
`define LCG_PATTERN_GENERATOR_CHECKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPGC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lpgc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LPGC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lpgc assertion failed");

`endif

// ----- design/lpgc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lpgc_pkg;

    // Largest divisor that the package number division supports.
    localparam int MAX_PACKAGE_SECTORS = 128;
    localparam int DIV_W = $clog2(MAX_PACKAGE_SECTORS + 1);

    // Divider runs one quotient bit per cycle over a 32-bit dividend.
    localparam int DIV_STEPS = 32;
    localparam int CNT_W = $clog2(DIV_STEPS);

    localparam logic [31:0] LCG_MUL   = 32'h0003_43FD;
    localparam logic [31:0] LCG_ADD   = 32'h0026_9EC3;
    localparam logic [31:0] LCG_RESET = 32'h691E_5A0F;

    localparam logic [7:0] SPP_RESET = 8'd128;

    // Item kinds carried in tuser.
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_GEN   = 2'd1;
    localparam logic [1:0] KIND_CHECK = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECTORS   = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_start;
        logic div_step;
        logic item_op;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_last;
    } status_t;

    // Zero divisor acts as one, large values saturate.
    function automatic logic [DIV_W-1:0] eff_divisor(input logic [7:0] spp);
        logic [DIV_W-1:0] d;
        if (spp == 8'd0) begin
            d = DIV_W'(1);
        end else if (32'(spp) > 32'(MAX_PACKAGE_SECTORS)) begin
            d = DIV_W'(MAX_PACKAGE_SECTORS);
        end else begin
            d = DIV_W'(spp);
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// ----- design/lpgc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lpgc_ctrl
    import lpgc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    input  wire logic [1:0] s_kind,
    output logic            s_tready,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output cmd_t            cmd,
    input  wire status_t    status
);

    state_t state_reg, state_next;
    logic   accept;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // A new word is taken when idle or when the held result leaves this cycle.
    assign s_tready = (state_reg == ST_IDLE) || ((state_reg == ST_OUT) && m_tready);
    assign accept   = s_tvalid && s_tready;

    // Next state and commands.
    always_comb begin
        state_next     = state_reg;
        cmd.load_start = 1'b0;
        cmd.div_step   = 1'b0;
        cmd.item_op    = 1'b0;
        m_tvalid       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_kind == KIND_START) begin
                        cmd.load_start = 1'b1;
                        state_next     = ST_DIV;
                    end else begin
                        cmd.item_op = 1'b1;
                        state_next  = ST_OUT;
                    end
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (accept) begin
                        if (s_kind == KIND_START) begin
                            cmd.load_start = 1'b1;
                            state_next     = ST_DIV;
                        end else begin
                            cmd.item_op = 1'b1;
                            state_next  = ST_OUT;
                        end
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/lpgc_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lpgc_datapath
    import lpgc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire cmd_t                 cmd,
    output status_t                   status,
    input  wire logic [1:0]           s_kind,
    input  wire logic [31:0]          s_start_sector,
    input  wire logic [7:0]           s_read_byte,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data,
    output logic [7:0]                expected_byte,
    output logic                      mismatch,
    output logic [31:0]               error_sector,
    output logic [8:0]                error_offset,
    output logic                      failed
);

    // Architectural state and configuration.
    logic signed [31:0] base_seed_reg, base_seed_next;
    logic [7:0]         spp_reg, spp_next;
    logic [31:0]        lcg_reg, lcg_next;
    logic [15:0]        byte_index_reg, byte_index_next;
    logic [31:0]        pkg_start_reg, pkg_start_next;
    logic               failed_reg, failed_next;

    // Divider state.
    logic [31:0]      quo_reg, quo_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] div_reg, div_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // Result registers.
    logic [7:0]  exp_reg, exp_next;
    logic        mism_reg, mism_next;
    logic [31:0] esec_reg, esec_next;
    logic [8:0]  eoff_reg, eoff_next;
    logic        fail_out_reg, fail_out_next;
    logic        load_out;

    // Helpers.
    logic [31:0]    lcg_step;
    logic [7:0]     pat_byte;
    logic [DIV_W:0] trial;
    logic [DIV_W:0] div_ext;
    logic [DIV_W:0] diff;
    logic           ge;
    logic [31:0]    quo_final;
    logic           is_byte;
    logic           bad;

    // One LCG step and the pattern byte it yields.
    assign lcg_step = lcg_reg * LCG_MUL + LCG_ADD;
    assign pat_byte = lcg_step[23:16];

    // Restoring divider step: shift in the next dividend bit and try to subtract.
    assign trial     = {rem_reg, quo_reg[31]};
    assign div_ext   = {1'b0, div_reg};
    assign diff      = trial - div_ext;
    assign ge        = (trial >= div_ext);
    assign quo_final = {quo_reg[30:0], ge};

    assign status.div_last = (cnt_reg == CNT_W'(DIV_STEPS - 1));

    assign is_byte = (s_kind == KIND_GEN) || (s_kind == KIND_CHECK);
    assign bad     = (s_kind == KIND_CHECK) && (s_read_byte != pat_byte) && !failed_reg;

    // Next-state logic.
    always_comb begin
        base_seed_next  = base_seed_reg;
        spp_next        = spp_reg;
        lcg_next        = lcg_reg;
        byte_index_next = byte_index_reg;
        pkg_start_next  = pkg_start_reg;
        failed_next     = failed_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        div_next        = div_reg;
        cnt_next        = cnt_reg;
        exp_next        = exp_reg;
        mism_next       = mism_reg;
        esec_next       = esec_reg;
        eoff_next       = eoff_reg;
        fail_out_next   = fail_out_reg;
        load_out        = 1'b0;

        // Configuration writes; indexes beyond the list are ignored.
        if (cfg_we) begin
            if (cfg_index == REG_BASE_SEED) begin
                base_seed_next = $signed(cfg_data);
            end else if (cfg_index == REG_SECTORS) begin
                spp_next = cfg_data[7:0];
            end
        end

        if (cmd.load_start) begin
            quo_next        = s_start_sector;
            rem_next        = '0;
            div_next        = eff_divisor(spp_reg);
            cnt_next        = '0;
            pkg_start_next  = s_start_sector;
            byte_index_next = '0;
            failed_next     = 1'b0;
        end

        if (cmd.div_step) begin
            quo_next = quo_final;
            rem_next = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
            // Last step seeds the LCG and posts the all-zero start result.
            if (status.div_last) begin
                lcg_next      = quo_final + $unsigned(base_seed_reg);
                load_out      = 1'b1;
                exp_next      = '0;
                mism_next     = 1'b0;
                esec_next     = '0;
                eoff_next     = '0;
                fail_out_next = 1'b0;
            end
        end

        if (cmd.item_op) begin
            load_out = 1'b1;
            if (is_byte) begin
                lcg_next        = lcg_step;
                byte_index_next = byte_index_reg + 16'd1;
                failed_next     = failed_reg || bad;
                exp_next        = pat_byte;
                mism_next       = bad;
                esec_next       = pkg_start_reg + {25'd0, byte_index_reg[15:9]};
                eoff_next       = byte_index_reg[8:0];
                fail_out_next   = failed_reg || bad;
            end else begin
                // Unused kind: no state change, report the current flag.
                exp_next      = '0;
                mism_next     = 1'b0;
                esec_next     = '0;
                eoff_next     = '0;
                fail_out_next = failed_reg;
            end
        end
    end

    // Control and architectural state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_seed_reg  <= '0;
            spp_reg        <= SPP_RESET;
            lcg_reg        <= LCG_RESET;
            byte_index_reg <= '0;
            pkg_start_reg  <= '0;
            failed_reg     <= 1'b0;
            cnt_reg        <= '0;
        end else begin
            base_seed_reg  <= base_seed_next;
            spp_reg        <= spp_next;
            lcg_reg        <= lcg_next;
            byte_index_reg <= byte_index_next;
            pkg_start_reg  <= pkg_start_next;
            failed_reg     <= failed_next;
            cnt_reg        <= cnt_next;
        end
    end

    // Divider operands and the result word.
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        if (load_out) begin
            exp_reg      <= exp_next;
            mism_reg     <= mism_next;
            esec_reg     <= esec_next;
            eoff_reg     <= eoff_next;
            fail_out_reg <= fail_out_next;
        end
    end

    assign expected_byte = exp_reg;
    assign mismatch      = mism_reg;
    assign error_sector  = esec_reg;
    assign error_offset  = eoff_reg;
    assign failed        = fail_out_reg;

endmodule

`default_nettype wire

// ----- design/lcg_pattern_generator_checker.sv -----
// Generate, check and unused-kind words: result valid in the cycle after accept,
// one word per cycle while m_tready stays high.
// Start words: result valid once the radix-2 restoring divider in the datapath
// has finished (one quotient bit per cycle, 32 bits).
// Reset (aresetn, synchronous, active low) clears control, loads the LCG with
// its reset seed, sectors_per_package with 128 and base_seed with 0.
`timescale 1ns / 1ps
`default_nettype none

`include "lcg_pattern_generator_checker_assert.svh"

module lcg_pattern_generator_checker
    import lpgc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Input words.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [39:0]          s_tdata,   // start_sector[31:0], read_byte[39:32]
    input  wire logic [1:0]           s_tuser,   // kind[1:0]
    // Result words.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [55:0]               m_tdata,   // expected_byte[7:0], mismatch[8],
                                                 // error_sector[40:9], error_offset[49:41],
                                                 // failed[50], zero[55:51]
    // Configuration writes.
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data
);

    cmd_t        cmd;
    status_t     status;
    logic [7:0]  expected_byte;
    logic        mismatch;
    logic [31:0] error_sector;
    logic [8:0]  error_offset;
    logic        failed;

    // Configuration is always taken.
    assign cfg_ready = 1'b1;

    lpgc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_kind   (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    lpgc_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_kind         (s_tuser),
        .s_start_sector (s_tdata[31:0]),
        .s_read_byte    (s_tdata[39:32]),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .expected_byte  (expected_byte),
        .mismatch       (mismatch),
        .error_sector   (error_sector),
        .error_offset   (error_offset),
        .failed         (failed)
    );

    // Pack the result word.
    assign m_tdata = {5'd0, failed, error_offset, error_sector, mismatch, expected_byte};

    // A stalled result blocks new input.
    `LPGC_ASSERT_IMP(a_stall_blocks_input, aclk, aresetn, m_tvalid && !m_tready, !s_tready)
    // A start word opens a division, so no result shows in the next cycle.
    `LPGC_ASSERT_NXT(a_start_divides, aclk, aresetn,
        s_tvalid && s_tready && (s_tuser == KIND_START), !m_tvalid && !s_tready)
    // A reported mismatch always comes with the failed flag.
    `LPGC_ASSERT_IMP(a_mismatch_sets_failed, aclk, aresetn, m_tvalid && m_tdata[8], m_tdata[50])

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import lpgc_pkg::*;

    // The package names only the three kinds that the block acts on.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_WORDS   = 520;
    localparam int RANDOM_WORDS = 380;
    localparam int PHASES       = 5;

    // Result word as it sits in m_tdata, highest bits first.
    typedef struct packed {
        logic [4:0]  pad;
        logic        failed;
        logic [8:0]  err_offset;
        logic [31:0] err_sector;
        logic        mismatch;
        logic [7:0]  pattern;
    } pattern_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [39:0]          s_tdata   = '0;
    logic [1:0]           s_tuser   = KIND_GEN;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [55:0]          m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_BASE_SEED;
    logic [31:0]          cfg_data  = '0;

    // Shadow copy of the block's registers and pattern state.
    logic [31:0] seed_reg   = 32'd0;
    logic [7:0]  spp_reg    = SPP_RESET;
    logic [31:0] lcg        = LCG_RESET;
    logic [15:0] byte_idx   = 16'd0;
    logic [31:0] pkg_start  = 32'd0;
    logic        fail_flag  = 1'b0;

    pattern_result_t pending_results[$];

    bit idle_en     = 1'b1;
    int error_count = 0;
    int words_sent  = 0;
    int n_starts    = 0;
    int n_checks    = 0;
    int n_flagged   = 0;
    int n_cfg       = 0;
    int cycles      = 0;

    lcg_pattern_generator_checker dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic logic [31:0] lcg_advance(input logic [31:0] s);
        return s * LCG_MUL + LCG_ADD;
    endfunction

    // Pattern byte that the next generate or check word will produce.
    function automatic logic [7:0] upcoming_pattern();
        logic [31:0] s;
        s = lcg_advance(lcg);
        return s[23:16];
    endfunction

    // Applies one accepted word to the shadow state and returns its result.
    function automatic pattern_result_t predict_pattern(input logic [1:0] kind,
                                                        input logic [31:0] sector,
                                                        input logic [7:0] rd_byte);
        pattern_result_t r;
        logic [7:0] div;
        r = '0;
        case (kind)
            KIND_START: begin
                if (spp_reg == 8'd0) begin
                    div = 8'd1;
                end else if (spp_reg > MAX_PACKAGE_SECTORS) begin
                    div = 8'(MAX_PACKAGE_SECTORS);
                end else begin
                    div = spp_reg;
                end
                lcg = sector / {24'd0, div} + seed_reg;
                byte_idx = 16'd0;
                pkg_start = sector;
                fail_flag = 1'b0;
                n_starts++;
            end
            KIND_GEN, KIND_CHECK: begin
                lcg = lcg_advance(lcg);
                r.pattern = lcg[23:16];
                r.err_sector = pkg_start + {25'd0, byte_idx[15:9]};
                r.err_offset = byte_idx[8:0];
                if (kind == KIND_CHECK) begin
                    n_checks++;
                    if (rd_byte != r.pattern && !fail_flag) begin
                        r.mismatch = 1'b1;
                        fail_flag = 1'b1;
                        n_flagged++;
                    end
                end
                byte_idx = byte_idx + 16'd1;
            end
            default: begin
            end
        endcase
        r.failed = fail_flag;
        return r;
    endfunction

    // Sends one input word, with an occasional gap in front of it.
    task automatic send_word(input logic [1:0] kind, input logic [31:0] sector,
                             input logic [7:0] rd_byte);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rd_byte, sector};
        s_tuser  <= kind;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(predict_pattern(kind, sector, rd_byte));
        words_sent++;
        @(negedge aclk);
    endtask

    // Check word carrying the right byte, or a corrupted one.
    task automatic check_byte(input bit corrupt);
        logic [7:0] b;
        b = upcoming_pattern();
        if (corrupt) begin
            b = b ^ 8'($urandom_range(1, 255));
        end
        send_word(KIND_CHECK, $urandom, b);
    endtask

    // Drops valid and waits until every expected word has come back.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_BASE_SEED) begin
            seed_reg = value;
        end else if (idx == REG_SECTORS) begin
            spp_reg = value[7:0];
        end
        n_cfg++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [31:0] pick_sector();
        case ($urandom_range(0, 3))
            0: return 32'($urandom_range(0, 1023));
            1: return 32'hFFFF_FFFF - 32'($urandom_range(0, 1023));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick_sectors_per_package();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd128;
            3: return 8'($urandom_range(129, 255));
            default: return 8'($urandom_range(2, 127));
        endcase
    endfunction

    function automatic logic [31:0] pick_base_seed();
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Pattern from the reset seed before any start, then the reset divisor.
    task automatic test_reset_state();
        send_word(KIND_GEN, 32'hFFFF_FFFF, 8'hFF);
        check_byte(1'b0);
        check_byte(1'b1);
        send_word(KIND_UNUSED, 32'hFFFF_FFFF, 8'hFF);
        send_word(KIND_START, 32'd1000, 8'h00);
        send_word(KIND_GEN, 32'd0, 8'h00);
    endtask

    // Seed wrap at both ends and the zero and oversized divisor cases.
    task automatic test_config_extremes();
        wait_idle();
        write_reg(REG_BASE_SEED, 32'h7FFF_FFFF);
        write_reg(REG_SECTORS, 32'd0);
        send_word(KIND_START, 32'hFFFF_FFFF, 8'h00);
        send_word(KIND_GEN, 32'd0, 8'h00);
        wait_idle();
        write_reg(REG_BASE_SEED, 32'h8000_0000);
        write_reg(REG_SECTORS, 32'd255);
        send_word(KIND_START, 32'hFFFF_FFFF, 8'hFF);
        send_word(KIND_CHECK, 32'd0, 8'hFF);
        wait_idle();
        write_reg(REG_BASE_SEED, 32'hFFFF_FFFF);
        write_reg(REG_SECTORS, 32'd1);
        send_word(KIND_START, 32'd0, 8'h00);
        send_word(KIND_GEN, 32'd0, 8'h00);
        wait_idle();
        write_reg(REG_SECTORS, 32'd129);
        send_word(KIND_START, 32'h8000_0000, 8'h00);
        send_word(KIND_CHECK, 32'hFFFF_FFFF, 8'h00);
        wait_idle();
        write_reg(REG_BASE_SEED, 32'd0);
        write_reg(REG_SECTORS, 32'd128);
    endtask

    // Only the first bad byte of a package is flagged; a start clears the flag.
    task automatic test_mismatch_flags();
        send_word(KIND_START, 32'd12345, 8'h00);
        check_byte(1'b0);
        check_byte(1'b1);
        check_byte(1'b1);
        send_word(KIND_GEN, 32'd0, 8'h00);
        send_word(KIND_UNUSED, 32'd0, 8'h00);
        send_word(KIND_START, 32'd12346, 8'h00);
        check_byte(1'b1);
    endtask

    // One package read past its first sector, with the error sector wrapping to zero.
    task automatic test_long_package();
        wait_idle();
        idle_en = 1'b0;
        write_reg(REG_SECTORS, 32'd1);
        send_word(KIND_START, 32'hFFFF_FFFF, 8'h00);
        for (int i = 0; i < LONG_WORDS; i++) begin
            if (i == 514) begin
                check_byte(1'b1);
            end else if (i % 128 == 127 || i >= 508) begin
                check_byte(1'b0);
            end else begin
                send_word(KIND_GEN, $urandom, 8'($urandom));
            end
        end
        idle_en = 1'b1;
    endtask

    // Mostly well-formed packages under changing settings, with some noise.
    task automatic test_random_traffic();
        int first;
        int n;
        first = words_sent;
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            write_reg(REG_BASE_SEED, pick_base_seed());
            write_reg(REG_SECTORS, 32'(pick_sectors_per_package()));
            if (phase == PHASES - 1) begin
                idle_en = 1'b0;
            end
            while (words_sent - first < RANDOM_WORDS * (phase + 1) / PHASES) begin
                if ($urandom_range(0, 9) < 8) begin
                    send_word(KIND_START, pick_sector(), 8'($urandom));
                    n = $urandom_range(1, 30);
                    repeat (n) begin
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3, 4, 5: check_byte($urandom_range(0, 19) == 0);
                            6, 7, 8: send_word(KIND_GEN, $urandom, 8'($urandom));
                            default: send_word(KIND_UNUSED, $urandom, 8'($urandom));
                        endcase
                    end
                end else begin
                    repeat ($urandom_range(1, 3)) begin
                        send_word(2'($urandom_range(0, 3)), pick_sector(), 8'($urandom));
                    end
                end
            end
        end
    endtask

    task automatic note_error(input string field, input logic [31:0] want,
                              input logic [31:0] got);
        error_count++;
        if (error_count <= 10) begin
            $display("[%0t] %s: expected %0h, got %0h", $realtime, field, want, got);
        end
    endtask

    // Result side stalls in random bursts while idling is enabled.
    initial begin : result_sink
        int stall;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else if (idle_en && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                stall = $urandom_range(1, 11) - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compares every accepted result word with the oldest prediction.
    always @(posedge aclk) begin : result_check
        pattern_result_t got;
        pattern_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_results.size() == 0) begin
                note_error("result word with nothing expected", 32'd0, m_tdata[31:0]);
            end else begin
                want = pending_results.pop_front();
                if (got.pattern !== want.pattern)
                    note_error("expected_byte", 32'(want.pattern), 32'(got.pattern));
                if (got.mismatch !== want.mismatch)
                    note_error("mismatch", 32'(want.mismatch), 32'(got.mismatch));
                if (got.err_sector !== want.err_sector)
                    note_error("error_sector", want.err_sector, got.err_sector);
                if (got.err_offset !== want.err_offset)
                    note_error("error_offset", 32'(want.err_offset), 32'(got.err_offset));
                if (got.failed !== want.failed)
                    note_error("failed", 32'(want.failed), 32'(got.failed));
                if (got.pad !== want.pad)
                    note_error("padding bits", 32'(want.pad), 32'(got.pad));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_results.size());
            $display("FAIL lcg_pattern_generator_checker");
            $finish;
        end
    end

    initial begin
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_state();
        test_config_extremes();
        test_mismatch_flags();
        test_long_package();
        test_random_traffic();

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Sent %0d words: %0d package starts, %0d byte checks, %0d flagged bytes.",
                 words_sent, n_starts, n_checks, n_flagged);
        $display("Made %0d register writes; %0d result errors in %0d cycles.",
                 n_cfg, error_count, cycles);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("PASS lcg_pattern_generator_checker");
        end else begin
            $display("FAIL lcg_pattern_generator_checker");
        end
        $finish;
    end

endmodule
